// ===== hdl/tsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants of the typed stack machine ALU.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DIV_STEPS   = VALUE_WIDTH + FRAC_BITS;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_CONST = 4'd1, OP_DIV = 4'd2, OP_EQ = 4'd3,
        OP_FALSE = 4'd4, OP_GT = 4'd5, OP_LT = 4'd6, OP_MUL = 4'd7,
        OP_NEG = 4'd8, OP_NOT = 4'd9, OP_PRINT = 4'd10, OP_RET = 4'd11,
        OP_SUB = 4'd12
    } t_opcode;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PRINTED  = 3'd1;
    localparam logic [2:0] ST_RETURNED = 3'd2;
    localparam logic [2:0] ST_TYPE     = 3'd3;
    localparam logic [2:0] ST_UNDER    = 3'd4;
    localparam logic [2:0] ST_OVER     = 3'd5;
    localparam logic [2:0] ST_HALTED   = 3'd6;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] constant_value;
        logic               constant_is_boolean;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] print_value;
        logic               print_is_boolean;
    } t_out_item;

    typedef struct packed {
        logic                          start;
        logic [VALUE_WIDTH-1:0]        num_mag;
        logic [VALUE_WIDTH-1:0]        den_mag;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic                   big;
        logic [VALUE_WIDTH-1:0] quot;
    } t_div_rsp;

endpackage

// ===== hdl/tsm_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_divider
// Restoring divider of magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsm_divider import tsm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    // The dividend is num << FRAC_BITS; only its top VALUE_WIDTH bits can be set.
    logic [DIV_STEPS-1:0]   r_num;
    logic [VALUE_WIDTH:0]   r_rem;
    logic [DIV_STEPS-1:0]   r_quot;
    logic [VALUE_WIDTH-1:0] r_den;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [VALUE_WIDTH:0]   n_trial;
    logic                   n_take;

    always_comb begin
        n_trial = {r_rem[VALUE_WIDTH-1:0], r_num[DIV_STEPS-1]};
        n_take  = n_trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS);
                r_num  <= {i_req.num_mag, {FRAC_BITS{1'b0}}};
                r_den  <= i_req.den_mag;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= n_take ? n_trial - {1'b0, r_den} : n_trial;
                r_quot <= {r_quot[DIV_STEPS-2:0], n_take};
                r_num  <= {r_num[DIV_STEPS-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.big  = |r_quot[DIV_STEPS-1:VALUE_WIDTH];
    assign o_rsp.quot = r_quot[VALUE_WIDTH-1:0];
endmodule

// ===== hdl/typed_stack_machine_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_stack_machine_alu
// Executes decoded bytecode instructions on a typed operand stack in RAM.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake              | Payload
// input   | in        | i_in_valid/o_in_ready  | i_in_data  (t_in_item)
// output  | out       | o_out_valid/i_out_ready| o_out_data (t_out_item)
//
// After the accepting edge an instruction reads the two top entries from the
// stack RAM in S_READ (registered read outputs) and executes in S_EXEC, so
// its result is valid in S_OUT after those two states. Push, return, unused
// opcodes and halted or underflowing instructions skip execute and go from
// S_READ straight to S_OUT. Multiply adds S_MUL for the product register;
// a divide by a non-zero integer adds S_DIV, which waits for the bit-serial
// divider. The input is ready again in the cycle after the result is taken.
// Reset is synchronous and clears the stack pointer and the halted flag; the
// RAM needs no clearing since only written entries are read.
// A stalled output holds the block in its result state until taken.
// ----------------------------------------------------------------------------
module typed_stack_machine_alu import tsm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);
    localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_DIV, S_MUL, S_OUT} t_state;

    // The stack is two RAMs (value and tag) with a common address; the second
    // port reads the entry just below the top.
    logic [VALUE_WIDTH-1:0] r_mem_val [STACK_DEPTH];
    logic                   r_mem_tag [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd_a, r_rd_b;
    logic                   r_tg_a, r_tg_b;

    t_state                 r_state;
    logic [SP_W-1:0]        r_sp;
    logic                   r_halted;
    t_in_item               r_in;
    t_out_item              r_out;
    logic                   r_we;
    logic [ADDR_W-1:0]      r_wa;
    logic [VALUE_WIDTH-1:0] r_wv;
    logic                   r_wt;
    logic signed [2*VALUE_WIDTH-1:0] r_prod;
    logic                   r_neg;

    t_div_req               n_div_req;
    t_div_rsp               w_div_rsp;

    tsm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Stack RAM ports: write from the registered write request, reads at sp-1
    // and sp-2 issued in all states; the values read in S_READ are the operands.
    logic [ADDR_W-1:0] n_ra_b, n_ra_a;
    assign n_ra_b = ADDR_W'(r_sp - 1'b1);
    assign n_ra_a = ADDR_W'(r_sp - 2'd2);

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem_val[r_wa] <= r_wv;
            r_mem_tag[r_wa] <= r_wt;
        end
        r_rd_b <= r_mem_val[n_ra_b];
        r_tg_b <= r_mem_tag[n_ra_b];
        r_rd_a <= r_mem_val[n_ra_a];
        r_tg_a <= r_mem_tag[n_ra_a];
    end

    // Decode.
    t_opcode w_op;
    logic    w_bin, w_un, w_push;
    assign w_op   = t_opcode'(r_in.opcode);
    assign w_bin  = (w_op == OP_ADD) || (w_op == OP_DIV) || (w_op == OP_EQ) ||
                    (w_op == OP_GT) || (w_op == OP_LT) || (w_op == OP_MUL) ||
                    (w_op == OP_SUB);
    assign w_un   = (w_op == OP_NEG) || (w_op == OP_NOT) || (w_op == OP_PRINT);
    assign w_push = (w_op == OP_CONST) || (w_op == OP_FALSE);

    // Execute-stage arithmetic on the registered operands.
    logic signed [VALUE_WIDTH-1:0] w_a, w_b;
    logic signed [VALUE_WIDTH:0]   w_sum, w_dif, w_neg;
    logic [VALUE_WIDTH-1:0]        w_mag_a, w_mag_b;
    assign w_a     = r_rd_a;
    assign w_b     = r_rd_b;
    assign w_sum   = {w_a[VALUE_WIDTH-1], w_a} + {w_b[VALUE_WIDTH-1], w_b};
    assign w_dif   = {w_a[VALUE_WIDTH-1], w_a} - {w_b[VALUE_WIDTH-1], w_b};
    assign w_neg   = -{w_b[VALUE_WIDTH-1], w_b};
    assign w_mag_a = w_a[VALUE_WIDTH-1] ? VALUE_WIDTH'(-w_a) : w_a;
    assign w_mag_b = w_b[VALUE_WIDTH-1] ? VALUE_WIDTH'(-w_b) : w_b;

    function automatic logic [VALUE_WIDTH-1:0] sat1(input logic signed [VALUE_WIDTH:0] v);
        if (v[VALUE_WIDTH] != v[VALUE_WIDTH-1])
            return v[VALUE_WIDTH] ? VMIN : VMAX;
        return v[VALUE_WIDTH-1:0];
    endfunction

    // Signs with magnitude to saturated two's complement.
    function automatic logic [VALUE_WIDTH-1:0] from_mag(input logic neg,
                                                        input logic [VALUE_WIDTH-1:0] mag,
                                                        input logic big);
        logic [VALUE_WIDTH-1:0] lim;
        logic [VALUE_WIDTH-1:0] m;
        lim = neg ? VMIN : VMAX;
        m   = (big || mag > lim) ? lim : mag;
        return neg ? VALUE_WIDTH'(-m) : m;
    endfunction

    // Product magnitude; r_prod holds the full unsigned product of magnitudes.
    logic [2*VALUE_WIDTH-1:0] w_pu;
    logic                     w_mbig;
    assign w_pu   = r_prod;
    assign w_mbig = |w_pu[2*VALUE_WIDTH-1:VALUE_WIDTH+FRAC_BITS];

    logic [SP_W-1:0] w_sp_full;
    assign w_sp_full = SP_W'(STACK_DEPTH);

    always_comb begin
        n_div_req.start   = 1'b0;
        n_div_req.num_mag = w_mag_a;
        n_div_req.den_mag = w_mag_b;
        if (r_state == S_EXEC && w_op == OP_DIV && !r_tg_a && !r_tg_b && w_b != 0)
            n_div_req.start = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_halted <= 1'b0;
            r_we     <= 1'b0;
        end else begin
            r_we <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // RAM reads issued this cycle; decide the early cases.
                    r_out   <= '{status: ST_OK, print_value: '0, print_is_boolean: 1'b0};
                    r_state <= S_EXEC;
                    if (r_halted) begin
                        r_out.status <= ST_HALTED;
                        r_state      <= S_OUT;
                    end else if ((w_bin && r_sp < SP_W'(2)) || (w_un && r_sp == '0)) begin
                        r_out.status <= ST_UNDER;
                        r_halted     <= 1'b1;
                        r_state      <= S_OUT;
                    end else if (w_push) begin
                        if (r_sp >= w_sp_full) begin
                            r_out.status <= ST_OVER;
                            r_halted     <= 1'b1;
                        end else begin
                            r_we <= 1'b1;
                            r_wa <= ADDR_W'(r_sp);
                            r_wt <= (w_op == OP_FALSE) || r_in.constant_is_boolean;
                            if (w_op == OP_FALSE)
                                r_wv <= '0;
                            else if (r_in.constant_is_boolean)
                                r_wv <= VALUE_WIDTH'(r_in.constant_value != 0);
                            else
                                r_wv <= VALUE_WIDTH'(r_in.constant_value);
                            r_sp <= r_sp + 1'b1;
                        end
                        r_state <= S_OUT;
                    end else if (!w_bin && !w_un) begin
                        if (w_op == OP_RET)
                            r_out.status <= ST_RETURNED;
                        r_state <= S_OUT;
                    end
                end
                S_EXEC: begin
                    r_state <= S_OUT;
                    r_wa    <= w_bin ? n_ra_a : n_ra_b;
                    r_neg   <= w_a[VALUE_WIDTH-1] ^ w_b[VALUE_WIDTH-1];
                    if (w_op == OP_PRINT) begin
                        r_out.status           <= ST_PRINTED;
                        r_out.print_value      <= 32'(signed'(w_b));
                        r_out.print_is_boolean <= r_tg_b;
                        r_sp                   <= r_sp - 1'b1;
                    end else if (w_op == OP_NEG || w_op == OP_NOT) begin
                        if ((w_op == OP_NEG) == r_tg_b) begin
                            r_out.status <= ST_TYPE;
                            r_halted     <= 1'b1;
                        end else begin
                            r_we <= 1'b1;
                            r_wt <= r_tg_b;
                            r_wv <= r_tg_b ? VALUE_WIDTH'(w_b == 0) : sat1(w_neg);
                        end
                    end else if (w_op == OP_EQ) begin
                        if (r_tg_a != r_tg_b) begin
                            r_out.status <= ST_TYPE;
                            r_halted     <= 1'b1;
                        end else begin
                            r_we <= 1'b1;
                            r_wt <= 1'b1;
                            r_wv <= VALUE_WIDTH'(w_a == w_b);
                            r_sp <= r_sp - 1'b1;
                        end
                    end else if (r_tg_a || r_tg_b) begin
                        r_out.status <= ST_TYPE;
                        r_halted     <= 1'b1;
                    end else begin
                        r_sp <= r_sp - 1'b1;
                        r_wt <= (w_op == OP_GT) || (w_op == OP_LT);
                        unique case (w_op)
                            OP_ADD: begin r_we <= 1'b1; r_wv <= sat1(w_sum); end
                            OP_SUB: begin r_we <= 1'b1; r_wv <= sat1(w_dif); end
                            OP_GT:  begin r_we <= 1'b1; r_wv <= VALUE_WIDTH'(w_a > w_b); end
                            OP_LT:  begin r_we <= 1'b1; r_wv <= VALUE_WIDTH'(w_a < w_b); end
                            OP_MUL: begin
                                r_prod  <= (2*VALUE_WIDTH)'(w_mag_a) *
                                           (2*VALUE_WIDTH)'(w_mag_b);
                                r_state <= S_MUL;
                            end
                            default: begin
                                if (w_b == 0) begin
                                    r_we <= 1'b1;
                                    r_wv <= (w_a == 0) ? '0 : (w_a[VALUE_WIDTH-1] ? VMIN : VMAX);
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_we    <= 1'b1;
                    r_wv    <= from_mag(r_neg && (w_pu != '0),
                                        w_pu[VALUE_WIDTH+FRAC_BITS-1:FRAC_BITS], w_mbig);
                    r_state <= S_OUT;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_we    <= 1'b1;
                        r_wv    <= from_mag(r_neg && (w_div_rsp.quot != '0 || w_div_rsp.big),
                                            w_div_rsp.quot, w_div_rsp.big);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;
endmodule

// ===== hdl/tsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_checker
// Port-level checks of the typed stack machine ALU.
// ----------------------------------------------------------------------------
module tsm_checker import tsm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);
    // One instruction in flight: no acceptance while a result waits.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("input taken while result pending");

    // After an error status is taken, no non-halted result is valid directly after the handshake.
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && (o_out_data.status == ST_TYPE ||
         o_out_data.status == ST_UNDER || o_out_data.status == ST_OVER))
        |=> !(o_out_valid && o_out_data.status != ST_HALTED)) else $error("not halted");

    // Print value is zero unless printed.
    a_pv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_PRINTED) |->
        (o_out_data.print_value == 0 && !o_out_data.print_is_boolean))
        else $error("stray print value");

    // A result never appears in the cycle right after acceptance.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid) else $error("early result");

    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped");
endmodule

bind typed_stack_machine_alu tsm_checker u_tsm_checker (.*);
